FILE: hdl/handover_ttt_decision_defines.svh
// Assertion macros used by the checker file of the handover decision block.
// Both forms sample on the rising edge of aclk and stay quiet while aresetn is low.
`ifndef HANDOVER_TTT_DECISION_DEFINES_SVH
`define HANDOVER_TTT_DECISION_DEFINES_SVH

// Same-cycle implication.
`define HTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/htd_pkg.sv
`default_nettype none

package htd_pkg;

    localparam int NUM_POINTS = 6;
    localparam int IDX_W      = 3;
    localparam int SNR_W      = 10;
    localparam int CNT_W      = 16;
    localparam int WIDE_W     = 12;

    typedef logic signed [SNR_W-1:0]  snr_t;
    typedef logic        [IDX_W-1:0]  idx_t;
    typedef logic        [CNT_W-1:0]  cnt_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam snr_t SNR_MIN = snr_t'(-512);
    localparam cnt_t CNT_MAX = '1;

    // Rule constants, quarter dB
    localparam wide_t MARGIN_BASE     = wide_t'(8);
    localparam wide_t MARGIN_MOBILITY = wide_t'(4);
    localparam wide_t NOISE_OFFSET    = wide_t'(8);
    localparam wide_t MARGIN_NOISE    = wide_t'(10);
    localparam wide_t HYST_OFFSET     = wide_t'(12);
    localparam wide_t FAIL_OFFSET     = wide_t'(12);

    typedef enum logic [1:0] {
        MODE_BASELINE = 2'd0,
        MODE_MOBILITY = 2'd1,
        MODE_NOISE    = 2'd2,
        MODE_HYST     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_STRATEGY   = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_HYSTERESIS = 3'd2,
        CFG_TTT        = 3'd3,
        CFG_TRANS      = 3'd4,
        CFG_PP_WINDOW  = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        mode_t      strategy;
        snr_t       threshold;
        logic [7:0] hysteresis;
        cnt_t       ttt;
        logic [7:0] trans_margin;
        cnt_t       pp_window;
    } cfg_t;

    typedef struct packed {
        idx_t best_idx;
        snr_t best_snr;
        snr_t second_snr;
    } sel_t;

    typedef struct packed {
        idx_t serving_point;
        idx_t best_point;
        logic in_transition;
        logic preparing;
        logic new_attempt;
        logic handover_done;
        logic handover_failed;
        logic pingpong;
        cnt_t trigger_delay_ticks;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/htd_lane.sv
`default_nettype none

// One lane per access point: decide whether this point is the strongest,
// lowest index winning ties, and offer its SNR to the second-best search.
module htd_lane (
    input  wire htd_pkg::idx_t lane_idx,
    input  wire htd_pkg::snr_t own_snr,
    input  wire htd_pkg::snr_t snr [htd_pkg::NUM_POINTS],
    output logic               is_best,
    output htd_pkg::snr_t      snr_rest
);
    import htd_pkg::*;

    always_comb begin
        is_best = 1'b1;
        for (int j = 0; j < NUM_POINTS; j++) begin
            if (IDX_W'(j) < lane_idx) begin
                if (!(own_snr > snr[j])) begin
                    is_best = 1'b0;
                end
            end else if (IDX_W'(j) > lane_idx) begin
                if (own_snr < snr[j]) begin
                    is_best = 1'b0;
                end
            end
        end
        // drop the winner from the runner-up search
        snr_rest = is_best ? SNR_MIN : own_snr;
    end

endmodule

`default_nettype wire

FILE: hdl/htd_merge.sv
`default_nettype none

// Combine lane verdicts: encode the winner, pick its SNR, find the runner-up.
module htd_merge (
    input  wire  is_best  [htd_pkg::NUM_POINTS],
    input  wire  htd_pkg::snr_t snr      [htd_pkg::NUM_POINTS],
    input  wire  htd_pkg::snr_t snr_rest [htd_pkg::NUM_POINTS],
    output htd_pkg::sel_t sel
);
    import htd_pkg::*;

    always_comb begin
        sel.best_idx   = '0;
        sel.best_snr   = SNR_MIN;
        sel.second_snr = SNR_MIN;
        for (int i = 0; i < NUM_POINTS; i++) begin
            if (is_best[i]) begin
                sel.best_idx = IDX_W'(i);
                sel.best_snr = snr[i];
            end
            if (snr_rest[i] > sel.second_snr) begin
                sel.second_snr = snr_rest[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/htd_ctrl.sv
`default_nettype none

// Serving point, candidate and time-to-trigger state; strategy rules.
module htd_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                accept,
    input  wire htd_pkg::cfg_t cfg,
    input  wire htd_pkg::snr_t snr [htd_pkg::NUM_POINTS],
    input  wire htd_pkg::sel_t sel,
    output htd_pkg::res_t      res
);
    import htd_pkg::*;

    idx_t serving_reg,   serving_next;
    idx_t previous_reg,  previous_next;
    logic prev_vld_reg,  prev_vld_next;
    idx_t cand_reg,      cand_next;
    logic cand_vld_reg,  cand_vld_next;
    cnt_t count_reg,     count_next;
    cnt_t since_reg,     since_next;

    always_comb begin
        snr_t  cur;
        wide_t cur_w;
        wide_t best_w;
        wide_t thr_w;
        wide_t margin_w;
        wide_t gap_w;
        cnt_t  since_inc;
        cnt_t  count_run;
        logic  rule;
        logic  need;
        logic  fire;
        logic  best_ok;

        since_inc = (since_reg == CNT_MAX) ? since_reg : since_reg + 1'b1;

        cur      = snr[serving_reg];
        cur_w    = WIDE_W'(cur);
        best_w   = WIDE_W'(sel.best_snr);
        thr_w    = WIDE_W'(cfg.threshold);
        margin_w = best_w - cur_w;
        gap_w    = best_w - WIDE_W'(sel.second_snr);

        unique case (cfg.strategy)
            MODE_BASELINE: rule = (cur_w < thr_w) || (margin_w > MARGIN_BASE);
            MODE_MOBILITY: rule = (cur_w < thr_w) || (margin_w > MARGIN_MOBILITY);
            MODE_NOISE:    rule = (cur_w < thr_w + NOISE_OFFSET) || (margin_w > MARGIN_NOISE);
            MODE_HYST:     rule = (margin_w > wide_t'({1'b0, cfg.hysteresis}))
                                  && (cur_w < thr_w + HYST_OFFSET);
            default:       rule = 1'b0;
        endcase
        need    = rule && (sel.best_idx != serving_reg);
        best_ok = best_w >= thr_w - FAIL_OFFSET;

        serving_next  = serving_reg;
        previous_next = previous_reg;
        prev_vld_next = prev_vld_reg;
        cand_next     = '0;
        cand_vld_next = 1'b0;
        count_next    = '0;
        since_next    = since_inc;
        count_run     = '0;
        fire          = 1'b0;

        res.new_attempt         = 1'b0;
        res.handover_done       = 1'b0;
        res.handover_failed     = 1'b0;
        res.pingpong            = 1'b0;
        res.trigger_delay_ticks = '0;

        if (need) begin
            if (!cand_vld_reg || (cand_reg != sel.best_idx)) begin
                count_run       = cnt_t'(1);
                res.new_attempt = 1'b1;
            end else begin
                count_run = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
            end
            fire = count_run >= cfg.ttt;
            if (fire) begin
                res.trigger_delay_ticks = count_run;
                if (best_ok) begin
                    res.pingpong = prev_vld_reg && (previous_reg == sel.best_idx)
                                   && (since_inc < cfg.pp_window);
                    previous_next     = serving_reg;
                    prev_vld_next     = 1'b1;
                    serving_next      = sel.best_idx;
                    since_next        = '0;
                    res.handover_done = 1'b1;
                end else begin
                    res.handover_failed = 1'b1;
                end
            end else begin
                cand_next     = sel.best_idx;
                cand_vld_next = 1'b1;
                count_next    = count_run;
            end
        end

        res.serving_point = serving_next;
        res.best_point    = sel.best_idx;
        res.in_transition = gap_w <= wide_t'({1'b0, cfg.trans_margin});
        res.preparing     = need;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serving_reg  <= '0;
            previous_reg <= '0;
            prev_vld_reg <= 1'b0;
            cand_reg     <= '0;
            cand_vld_reg <= 1'b0;
            count_reg    <= '0;
            since_reg    <= CNT_MAX;
        end else if (accept) begin
            serving_reg  <= serving_next;
            previous_reg <= previous_next;
            prev_vld_reg <= prev_vld_next;
            cand_reg     <= cand_next;
            cand_vld_reg <= cand_vld_next;
            count_reg    <= count_next;
            since_reg    <= since_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/handover_ttt_decision.sv
// Handover decision with hysteresis and time-to-trigger. Each input request
// is one measurement tick carrying a signed quarter-dB SNR for each of six
// access points; each produces exactly one result request giving the serving
// point after the tick, the strongest point, the transition flag, and the
// attempt, success, failure and ping-pong flags with the trigger delay. One
// tick is taken every clock cycle while s_ready is high, and its result is
// registered on acceptance: six compare lanes, the merge stage and
// the state update together form a single combinational stage ahead of that
// register. s_ready stays high while the output register is empty or being
// drained. Configuration writes (index 0 to 5, other indexes ignored, data
// masked to the register width) are always ready and must only be issued
// while no tick is in flight.
`default_nettype none

module handover_ttt_decision (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_addr,
    input  wire  [15:0] cfg_data,
    // measurement tick
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [9:0]  s_snr_ap0,
    input  wire  [9:0]  s_snr_ap1,
    input  wire  [9:0]  s_snr_ap2,
    input  wire  [9:0]  s_snr_ap3,
    input  wire  [9:0]  s_snr_ap4,
    input  wire  [9:0]  s_snr_ap5,
    // decision
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_serving_point,
    output logic [2:0]  m_best_point,
    output logic        m_in_transition,
    output logic        m_preparing,
    output logic        m_new_attempt,
    output logic        m_handover_done,
    output logic        m_handover_failed,
    output logic        m_pingpong,
    output logic [15:0] m_trigger_delay_ticks
);
    import htd_pkg::*;

    cfg_t cfg_reg;
    snr_t snr_arr  [NUM_POINTS];
    logic is_best  [NUM_POINTS];
    snr_t snr_rest [NUM_POINTS];
    sel_t sel;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic accept;

    // Register file: accept every write, drop unknown indexes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strategy     <= MODE_BASELINE;
            cfg_reg.threshold    <= snr_t'(60);
            cfg_reg.hysteresis   <= 8'd0;
            cfg_reg.ttt          <= cnt_t'(2);
            cfg_reg.trans_margin <= 8'd8;
            cfg_reg.pp_window    <= cnt_t'(20);
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_STRATEGY:   cfg_reg.strategy     <= mode_t'(cfg_data[1:0]);
                CFG_THRESHOLD:  cfg_reg.threshold    <= snr_t'(cfg_data[SNR_W-1:0]);
                CFG_HYSTERESIS: cfg_reg.hysteresis   <= cfg_data[7:0];
                CFG_TTT:        cfg_reg.ttt          <= cfg_data;
                CFG_TRANS:      cfg_reg.trans_margin <= cfg_data[7:0];
                CFG_PP_WINDOW:  cfg_reg.pp_window    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Take a new tick whenever the output register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign snr_arr[0] = snr_t'(s_snr_ap0);
    assign snr_arr[1] = snr_t'(s_snr_ap1);
    assign snr_arr[2] = snr_t'(s_snr_ap2);
    assign snr_arr[3] = snr_t'(s_snr_ap3);
    assign snr_arr[4] = snr_t'(s_snr_ap4);
    assign snr_arr[5] = snr_t'(s_snr_ap5);

    // One compare lane per access point.
    for (genvar i = 0; i < NUM_POINTS; i++) begin : g_lane
        htd_lane u_lane (
            .lane_idx (IDX_W'(i)),
            .own_snr  (snr_arr[i]),
            .snr      (snr_arr),
            .is_best  (is_best[i]),
            .snr_rest (snr_rest[i])
        );
    end

    // Merge lane verdicts into best and runner-up.
    htd_merge u_merge (
        .is_best  (is_best),
        .snr      (snr_arr),
        .snr_rest (snr_rest),
        .sel      (sel)
    );

    // Advance the decision state only on an accepted tick.
    htd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cfg     (cfg_reg),
        .snr     (snr_arr),
        .sel     (sel),
        .res     (res)
    );

    // Output register: load on accept, hold while stalled, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_serving_point       = res_reg.serving_point;
    assign m_best_point          = res_reg.best_point;
    assign m_in_transition       = res_reg.in_transition;
    assign m_preparing           = res_reg.preparing;
    assign m_new_attempt         = res_reg.new_attempt;
    assign m_handover_done       = res_reg.handover_done;
    assign m_handover_failed     = res_reg.handover_failed;
    assign m_pingpong            = res_reg.pingpong;
    assign m_trigger_delay_ticks = res_reg.trigger_delay_ticks;

endmodule

`default_nettype wire

FILE: hdl/htd_checker.sv
`default_nettype none
`include "handover_ttt_decision_defines.svh"

module htd_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [2:0]  m_serving_point,
    input wire [2:0]  m_best_point,
    input wire        m_preparing,
    input wire        m_new_attempt,
    input wire        m_handover_done,
    input wire        m_handover_failed,
    input wire        m_pingpong,
    input wire [15:0] m_trigger_delay_ticks
);

    wire        both      = m_handover_done && m_handover_failed;
    wire        on_best   = (m_serving_point == m_best_point);
    wire        done_seen = m_valid && m_handover_done;
    wire        pp_seen   = m_valid && m_pingpong;
    wire        fired     = m_handover_done || m_handover_failed;
    wire        has_delay = |m_trigger_delay_ticks;
    wire        stalled   = m_valid && !m_ready;
    wire [20:0] held      = {m_serving_point, m_trigger_delay_ticks, m_preparing, m_new_attempt};

    `HTD_ASSERT_NOW(a_done_xor_fail, m_valid, !both, "done and failed together")
    `HTD_ASSERT_NOW(a_done_serving, done_seen, on_best, "not on best point")
    `HTD_ASSERT_NOW(a_pingpong_done, pp_seen, m_handover_done && on_best, "stray ping-pong")
    `HTD_ASSERT_NOW(a_delay_fire, m_valid, has_delay == fired, "delay disagrees with outcome")
    `HTD_ASSERT_NEXT(a_hold, stalled, m_valid && $stable(held), "stalled result changed")

endmodule

bind handover_ttt_decision htd_checker u_htd_checker (.*);

`default_nettype wire
